[hdl/eulr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package eulr_pkg;

	localparam int AngleFracBits = 6;
	localparam int OutFracBits = 14;
	localparam int TrigBits = 30;
	localparam int CordicSteps = 30;
	localparam int FullTurn = 360 << AngleFracBits;
	localparam int PhaseRecipBits = 45;
	localparam int DataW = 34;
	localparam logic signed [DataW-1:0] CordicGain = 34'sd652032874;
	localparam logic signed [DataW-1:0] TrigOne = 34'sd1 << TrigBits;

	typedef struct packed {
		logic signed [15:0] angle_x_deg;
		logic signed [15:0] angle_y_deg;
		logic signed [15:0] angle_z_deg;
	} in_req_t;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
	} out_req_t;

	typedef struct packed {
		logic signed [DataW-1:0] x;
		logic signed [DataW-1:0] y;
		logic signed [DataW-1:0] z;
		logic flip;
	} rot_t;

	typedef struct packed {
		logic signed [DataW-1:0] c;
		logic signed [DataW-1:0] s;
	} cs_t;

	function automatic logic signed [DataW-1:0] atan_phase(input int i);
		case (i)
			0: atan_phase = 34'sd536870912;
			1: atan_phase = 34'sd316933406;
			2: atan_phase = 34'sd167458907;
			3: atan_phase = 34'sd85004756;
			4: atan_phase = 34'sd42667331;
			5: atan_phase = 34'sd21354465;
			6: atan_phase = 34'sd10679838;
			7: atan_phase = 34'sd5340245;
			8: atan_phase = 34'sd2670163;
			9: atan_phase = 34'sd1335087;
			10: atan_phase = 34'sd667544;
			11: atan_phase = 34'sd333772;
			12: atan_phase = 34'sd166886;
			13: atan_phase = 34'sd83443;
			14: atan_phase = 34'sd41722;
			15: atan_phase = 34'sd20861;
			16: atan_phase = 34'sd10430;
			17: atan_phase = 34'sd5215;
			18: atan_phase = 34'sd2608;
			19: atan_phase = 34'sd1304;
			20: atan_phase = 34'sd652;
			21: atan_phase = 34'sd326;
			22: atan_phase = 34'sd163;
			23: atan_phase = 34'sd81;
			24: atan_phase = 34'sd41;
			25: atan_phase = 34'sd20;
			26: atan_phase = 34'sd10;
			27: atan_phase = 34'sd5;
			28: atan_phase = 34'sd3;
			29: atan_phase = 34'sd1;
			default: atan_phase = '0;
		endcase
	endfunction

	function automatic logic signed [DataW-1:0] clamp_one(input logic signed [DataW-1:0] v);
		if (v > TrigOne) begin
			clamp_one = TrigOne;
		end else if (v < -TrigOne) begin
			clamp_one = -TrigOne;
		end else begin
			clamp_one = v;
		end
	endfunction

	function automatic logic signed [DataW-1:0] mul30(input logic signed [DataW-1:0] p,
			input logic signed [DataW-1:0] q);
		logic signed [2*DataW-1:0] prod;
		prod = p * q + (68'sd1 <<< (TrigBits - 1));
		mul30 = DataW'(prod >>> TrigBits);
	endfunction

	function automatic logic signed [15:0] to_out(input logic signed [DataW-1:0] v);
		logic signed [DataW-1:0] r;
		logic signed [DataW-1:0] lim;
		lim = 34'sd1 <<< OutFracBits;
		r = (v + (34'sd1 <<< (TrigBits - OutFracBits - 1))) >>> (TrigBits - OutFracBits);
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		to_out = 16'(r);
	endfunction

endpackage
`default_nettype wire

[hdl/euler_xyz_rotation_matrix_top.sv]
// Euler X-Y-Z rotation matrix: takes three angles (degrees x64) and returns the nine
// Q2.14 elements of Rx*Ry*Rz. One request per cycle is taken unless the output stalls;
// the pipeline is the 30-cell CORDIC chain plus phase, clamp, multiply and rounding
// stages. The whole pipeline advances only when its last stage is free or being taken.
`timescale 1ns / 1ps
`default_nettype none
module euler_xyz_rotation_matrix_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire eulr_pkg::in_req_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output eulr_pkg::out_req_t out_data
);
	import eulr_pkg::*;

	localparam int Latency = CordicSteps + 5;

	logic en;
	logic [Latency-1:0] vld_q;
	cs_t tx, ty, tz;

	assign en = !vld_q[Latency-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[Latency-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Latency-2:0], in_valid};
		end
	end

	eulr_trig u_tx (.clk(clk), .arst_n(arst_n), .en(en), .angle(in_data.angle_x_deg), .cs(tx));
	eulr_trig u_ty (.clk(clk), .arst_n(arst_n), .en(en), .angle(in_data.angle_y_deg), .cs(ty));
	eulr_trig u_tz (.clk(clk), .arst_n(arst_n), .en(en), .angle(in_data.angle_z_deg), .cs(tz));

	eulr_matrix u_mat (.clk(clk), .arst_n(arst_n), .en(en), .tx(tx), .ty(ty), .tz(tz),
		.m(out_data));
endmodule
`default_nettype wire

[hdl/eulr_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module eulr_cell (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [4:0] step,
	input wire logic en,
	input wire eulr_pkg::rot_t d,
	output eulr_pkg::rot_t q
);
	import eulr_pkg::*;

	rot_t nx;
	logic signed [DataW-1:0] dx;
	logic signed [DataW-1:0] dy;

	always_comb begin
		dx = d.y >>> step;
		dy = d.x >>> step;
		nx.flip = d.flip;
		if (!d.z[DataW-1]) begin
			nx.x = d.x - dx;
			nx.y = d.y + dy;
			nx.z = d.z - atan_phase(int'(step));
		end else begin
			nx.x = d.x + dx;
			nx.y = d.y - dy;
			nx.z = d.z + atan_phase(int'(step));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nx;
		end
	end
endmodule
`default_nettype wire

[hdl/eulr_trig.sv]
`timescale 1ns / 1ps
`default_nettype none
module eulr_trig (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic signed [15:0] angle,
	output eulr_pkg::cs_t cs
);
	import eulr_pkg::*;

	localparam int TurnShift = AngleFracBits + 3;
	localparam int TurnOdd = FullTurn >> TurnShift;
	localparam int RecipShift = 50;
	localparam int PhaseLsb = RecipShift - 32 + TurnShift;
	localparam logic [PhaseRecipBits-1:0] Recip = PhaseRecipBits'(
		((64'd1 << RecipShift) + 64'(TurnOdd) - 64'd1) / 64'(TurnOdd));

	logic signed [15:0] a_mod;
	logic [31:0] phase;
	logic [PhaseLsb+31:0] prod;
	logic signed [DataW-1:0] theta;
	rot_t seed_s1;
	rot_t chain [CordicSteps+1];

	always_comb begin
		a_mod = angle;
		if (a_mod < 0) a_mod = a_mod + 16'(FullTurn);
		if (a_mod < 0) a_mod = a_mod + 16'(FullTurn);
		if (a_mod >= 16'(FullTurn)) a_mod = a_mod - 16'(FullTurn);
		if (a_mod >= 16'(FullTurn)) a_mod = a_mod - 16'(FullTurn);
		prod = (PhaseLsb+32)'(a_mod[14:0]) * (PhaseLsb+32)'(Recip);
		phase = prod[PhaseLsb+31:PhaseLsb];
		theta = DataW'(signed'(phase));
		seed_s1.flip = 1'b0;
		if (theta > (34'sd1 <<< 30)) begin
			theta = theta - (34'sd1 <<< 31);
			seed_s1.flip = 1'b1;
		end else if (theta < -(34'sd1 <<< 30)) begin
			theta = theta + (34'sd1 <<< 31);
			seed_s1.flip = 1'b1;
		end
		seed_s1.x = CordicGain;
		seed_s1.y = '0;
		seed_s1.z = theta;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain[0] <= '0;
		end else if (en) begin
			chain[0] <= seed_s1;
		end
	end

	for (genvar i = 0; i < CordicSteps; i++) begin : g_cell
		eulr_cell u_cell (
			.clk(clk), .arst_n(arst_n), .step(5'(i)), .en(en),
			.d(chain[i]), .q(chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs <= '0;
		end else if (en) begin
			cs.c <= chain[CordicSteps].flip ? -clamp_one(chain[CordicSteps].x)
				: clamp_one(chain[CordicSteps].x);
			cs.s <= chain[CordicSteps].flip ? -clamp_one(chain[CordicSteps].y)
				: clamp_one(chain[CordicSteps].y);
		end
	end
endmodule
`default_nettype wire

[hdl/eulr_matrix.sv]
`timescale 1ns / 1ps
`default_nettype none
module eulr_matrix (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire eulr_pkg::cs_t tx,
	input wire eulr_pkg::cs_t ty,
	input wire eulr_pkg::cs_t tz,
	output eulr_pkg::out_req_t m
);
	import eulr_pkg::*;

	logic signed [DataW-1:0] a_s1, b_s1, c_s1, d_s1, cz_s1, sz_s1, cx_s1, sx_s1, cy_s1, sy_s1;
	logic signed [DataW-1:0] p0_s2, p1_s2, p3a_s2, p3b_s2, p4a_s2, p4b_s2;
	logic signed [DataW-1:0] p6a_s2, p6b_s2, p7a_s2, p7b_s2, sy_s2, b_s2, d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_s1 <= '0; b_s1 <= '0; c_s1 <= '0; d_s1 <= '0;
			cx_s1 <= '0; sx_s1 <= '0; cy_s1 <= '0; sy_s1 <= '0;
			cz_s1 <= '0; sz_s1 <= '0;
			p0_s2 <= '0; p1_s2 <= '0; p3a_s2 <= '0; p3b_s2 <= '0;
			p4a_s2 <= '0; p4b_s2 <= '0; p6a_s2 <= '0; p6b_s2 <= '0;
			p7a_s2 <= '0; p7b_s2 <= '0; sy_s2 <= '0; b_s2 <= '0; d_s2 <= '0;
			m <= '0;
		end else if (en) begin
			a_s1 <= mul30(tx.s, ty.s);
			b_s1 <= -mul30(tx.s, ty.c);
			c_s1 <= -mul30(tx.c, ty.s);
			d_s1 <= mul30(tx.c, ty.c);
			cx_s1 <= tx.c; sx_s1 <= tx.s; cy_s1 <= ty.c; sy_s1 <= ty.s;
			cz_s1 <= tz.c; sz_s1 <= tz.s;
			p0_s2 <= mul30(cy_s1, cz_s1);
			p1_s2 <= -mul30(cy_s1, sz_s1);
			p3a_s2 <= mul30(a_s1, cz_s1);
			p3b_s2 <= mul30(cx_s1, sz_s1);
			p4a_s2 <= mul30(cx_s1, cz_s1);
			p4b_s2 <= mul30(a_s1, sz_s1);
			p6a_s2 <= mul30(c_s1, cz_s1);
			p6b_s2 <= mul30(sx_s1, sz_s1);
			p7a_s2 <= mul30(sx_s1, cz_s1);
			p7b_s2 <= mul30(c_s1, sz_s1);
			sy_s2 <= sy_s1; b_s2 <= b_s1; d_s2 <= d_s1;
			m.m00 <= to_out(p0_s2);
			m.m01 <= to_out(p1_s2);
			m.m02 <= to_out(sy_s2);
			m.m10 <= to_out(p3a_s2 + p3b_s2);
			m.m11 <= to_out(p4a_s2 - p4b_s2);
			m.m12 <= to_out(b_s2);
			m.m20 <= to_out(p6a_s2 + p6b_s2);
			m.m21 <= to_out(p7a_s2 - p7b_s2);
			m.m22 <= to_out(d_s2);
		end
	end
endmodule
`default_nettype wire

[hdl/eulr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module eulr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire eulr_pkg::out_req_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("hold");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("ready");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready) else $error("stall");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.m00 <= 16'sd16384 && out_data.m00 >= -16'sd16384)
		else $error("range");
endmodule

bind euler_xyz_rotation_matrix_top eulr_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .out_data(out_data));
`default_nettype wire

[tb/euler_xyz_rotation_matrix_top_test.sv]
`timescale 1ns / 1ps
module euler_xyz_rotation_matrix_top_test;
	import eulr_pkg::*;

	localparam int Latency = 35;
	localparam int CycleLimit = 400000;
	localparam longint TrigUnit = 64'sd1 << 30;
	localparam longint Gain = 64'sd652032874;
	localparam longint FullAngle = 64'sd23040;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_req_t in_data;
	logic out_valid;
	logic out_ready;
	out_req_t out_data;

	in_req_t pending_angles[$];
	out_req_t expected_matrices[$];
	int mismatches;
	int cycle_count;
	int drive_gap;
	int sink_stall;
	bit calm_phase;
	bit hold_for_drain;
	bit stimulus_done;

	longint atan_steps[30] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1};

	euler_xyz_rotation_matrix_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	function automatic longint sat_unit(longint v);
		if (v > TrigUnit) return TrigUnit;
		if (v < -TrigUnit) return -TrigUnit;
		return v;
	endfunction

	function automatic void cos_sin(input logic signed [15:0] angle, output longint c,
			output longint s);
		longint a;
		longint theta;
		longint x;
		longint y;
		longint dx;
		longint dy;
		bit flip;
		a = longint'(angle) % FullAngle;
		if (a < 0) a += FullAngle;
		theta = (a << 32) / FullAngle;
		theta &= 64'hFFFF_FFFF;
		if (theta >= (64'sd1 << 31)) theta -= 64'sd1 << 32;
		flip = 0;
		if (theta > (64'sd1 << 30)) begin
			theta -= 64'sd1 << 31;
			flip = 1;
		end else if (theta < -(64'sd1 << 30)) begin
			theta += 64'sd1 << 31;
			flip = 1;
		end
		x = Gain;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (theta >= 0) begin
				x -= dx;
				y += dy;
				theta -= atan_steps[i];
			end else begin
				x += dx;
				y -= dy;
				theta += atan_steps[i];
			end
		end
		x = sat_unit(x);
		y = sat_unit(y);
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint fx_mul(longint p, longint q);
		return (p * q + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic logic signed [15:0] to_q14(longint v);
		longint r;
		r = (v + (64'sd1 <<< 15)) >>> 16;
		if (r > 16384) r = 16384;
		if (r < -16384) r = -16384;
		return 16'(r);
	endfunction

	function automatic out_req_t rotation_matrix(in_req_t req);
		longint cx, sx, cy, sy, cz, sz, a, b, c, d;
		out_req_t m;
		cos_sin(req.angle_x_deg, cx, sx);
		cos_sin(req.angle_y_deg, cy, sy);
		cos_sin(req.angle_z_deg, cz, sz);
		a = fx_mul(sx, sy);
		b = -fx_mul(sx, cy);
		c = -fx_mul(cx, sy);
		d = fx_mul(cx, cy);
		m.m00 = to_q14(fx_mul(cy, cz));
		m.m01 = to_q14(-fx_mul(cy, sz));
		m.m02 = to_q14(sy);
		m.m10 = to_q14(fx_mul(a, cz) + fx_mul(cx, sz));
		m.m11 = to_q14(fx_mul(cx, cz) - fx_mul(a, sz));
		m.m12 = to_q14(b);
		m.m20 = to_q14(fx_mul(c, cz) + fx_mul(sx, sz));
		m.m21 = to_q14(fx_mul(sx, cz) - fx_mul(c, sz));
		m.m22 = to_q14(d);
		return m;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
			cycle_count);
		mismatches++;
	endtask

	function automatic logic signed [15:0] any_angle();
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: return 16'(int'($urandom_range(0, 46080)) - 23040);
			2: return 16'(int'($urandom_range(0, 8)) * 2880 - 11520);
			default: return 16'(int'($urandom_range(0, 2 * 360 * 64)) - 23040);
		endcase
	endfunction

	task automatic push_angles(input logic signed [15:0] ax, input logic signed [15:0] ay,
			input logic signed [15:0] az);
		in_req_t r;
		r.angle_x_deg = ax;
		r.angle_y_deg = ay;
		r.angle_z_deg = az;
		pending_angles.push_back(r);
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		logic signed [15:0] edge_vals[12] = '{0, 23040, -23040, 5760, -5760, 11520, -11520,
			32767, -32768, 1, -1, 17280};
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		foreach (edge_vals[i])
			push_angles(edge_vals[i], edge_vals[(i + 3) % 12], edge_vals[(i + 7) % 12]);
		push_angles(16'sh5555, 16'shAAAA, 16'sh7FFF);
		push_angles(16'shAAAA, 16'sh5555, 16'sh8000);
		push_angles(2880, 2880, 2880);
		for (int i = 0; i < 1850; i++)
			push_angles(any_angle(), any_angle(), any_angle());
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			in_data <= '0;
			drive_gap <= 0;
			hold_for_drain <= 0;
			stimulus_done <= 0;
		end else begin
			if (in_valid && in_ready && pending_angles.size() == 900)
				hold_for_drain <= 1;
			if (hold_for_drain && expected_matrices.size() == 0 && !in_valid)
				hold_for_drain <= 0;
			if (!in_valid || in_ready) begin
				if (in_valid)
					expected_matrices.push_back(rotation_matrix(in_data));
				if (drive_gap > 0) begin
					drive_gap <= drive_gap - 1;
					in_valid <= 0;
				end else if (hold_for_drain && !(in_valid && in_ready &&
						pending_angles.size() == 900) && expected_matrices.size() != 0) begin
					in_valid <= 0;
				end else if (pending_angles.size() != 0 && !(in_valid && in_ready &&
						pending_angles.size() == 900)) begin
					in_valid <= 1;
					in_data <= pending_angles.pop_front();
					if (!calm_phase && $urandom_range(0, 7) == 0)
						drive_gap <= $urandom_range(1, 11);
				end else begin
					in_valid <= 0;
					if (pending_angles.size() == 0 && cycle_count > 20)
						stimulus_done <= 1;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
			sink_stall <= 0;
		end else if (sink_stall > 0) begin
			sink_stall <= sink_stall - 1;
			out_ready <= 0;
		end else begin
			out_ready <= 1;
			if (!calm_phase && $urandom_range(0, 9) == 0)
				sink_stall <= $urandom_range(1, 11);
		end
	end

	always @(posedge clk) begin
		out_req_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_matrices.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				want = expected_matrices.pop_front();
				if (out_data.m00 !== want.m00) report_mismatch("m00", out_data.m00, want.m00);
				if (out_data.m01 !== want.m01) report_mismatch("m01", out_data.m01, want.m01);
				if (out_data.m02 !== want.m02) report_mismatch("m02", out_data.m02, want.m02);
				if (out_data.m10 !== want.m10) report_mismatch("m10", out_data.m10, want.m10);
				if (out_data.m11 !== want.m11) report_mismatch("m11", out_data.m11, want.m11);
				if (out_data.m12 !== want.m12) report_mismatch("m12", out_data.m12, want.m12);
				if (out_data.m20 !== want.m20) report_mismatch("m20", out_data.m20, want.m20);
				if (out_data.m21 !== want.m21) report_mismatch("m21", out_data.m21, want.m21);
				if (out_data.m22 !== want.m22) report_mismatch("m22", out_data.m22, want.m22);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		calm_phase <= pending_angles.size() < 300 && cycle_count > 100;
		if (cycle_count >= CycleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		cycle_count = 0;
		calm_phase = 0;
		wait (stimulus_done);
		wait (expected_matrices.size() == 0);
		repeat (Latency + 10) @(posedge clk);
		if (mismatches == 0 && expected_matrices.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
